[rtl/pse_pkg.sv]
package pse_pkg;

  localparam logic [7:0] TAB_BYTE      = 8'h09;
  localparam logic [7:0] PRINT_LO      = 8'h20;
  localparam logic [7:0] PRINT_HI      = 8'h7E;

  localparam int         CFG_INDEX_W   = 8;
  localparam int         CFG_DATA_W    = 7;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_OFFSET = 8'd1;

  localparam logic [6:0] MIN_LENGTH_RESET    = 7'd4;
  localparam logic       REPORT_OFFSET_RESET = 1'b0;

  localparam logic       KIND_CHAR = 1'b0;
  localparam logic       KIND_TERM = 1'b1;

  typedef enum logic [1:0] {
    OP_TERM  = 2'd0,
    OP_PASS  = 2'd1,
    OP_BURST = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

endpackage

[rtl/pse_cmdq.sv]
module pse_cmdq #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

[rtl/pse_front.sv]
module pse_front #(
  parameter int MAX_MIN_LENGTH = 64,
  parameter int OFFSET_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic [7:0]                          in_data_byte,
  output logic                                in_full,
  input  logic [6:0]                          min_length,
  input  logic                                report_offset,
  input  logic                                q_full,
  input  logic                                burst_done,
  output logic                                q_push,
  output pse_pkg::cmd_t                       cmd,
  output logic [$clog2(MAX_MIN_LENGTH+1)-1:0] cmd_count,
  output logic [OFFSET_WIDTH-1:0]             cmd_offset,
  output logic                                wr_en,
  output logic [$clog2(MAX_MIN_LENGTH)-1:0]   wr_addr,
  output logic [7:0]                          wr_data
);

  localparam int CW = $clog2(MAX_MIN_LENGTH + 1);
  localparam int AW = $clog2(MAX_MIN_LENGTH);
  localparam int LW = (CW > 7) ? CW : 7;

  logic [CW-1:0]           held_r, held_nxt;
  logic                    in_string_r, in_string_nxt;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic                    busy_r, busy_nxt;

  logic          accept;
  logic          printable;
  logic          room;
  logic [CW-1:0] new_count;
  logic          reached;

  assign in_full   = q_full || busy_r;
  assign accept    = in_push && !in_full;
  assign printable = (in_data_byte inside {[pse_pkg::PRINT_LO:pse_pkg::PRINT_HI]}) ||
                     (in_data_byte == pse_pkg::TAB_BYTE);
  assign room      = (held_r < CW'(MAX_MIN_LENGTH));
  assign new_count = room ? held_r + CW'(1) : held_r;
  assign reached   = (LW'(new_count) >= LW'(min_length)) ||
                     (new_count == CW'(MAX_MIN_LENGTH));

  assign wr_addr = held_r[AW-1:0];
  assign wr_data = in_data_byte;

  always_comb begin
    held_nxt      = held_r;
    in_string_nxt = in_string_r;
    pos_nxt       = pos_r;
    busy_nxt      = busy_r;
    q_push        = 1'b0;
    wr_en         = 1'b0;
    cmd.op        = pse_pkg::OP_PASS;
    cmd.data      = in_data_byte;
    cmd_count     = new_count;
    cmd_offset    = report_offset ? pos_r - OFFSET_WIDTH'(new_count - CW'(1))
                                  : '0;
    if (burst_done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      pos_nxt = pos_r + OFFSET_WIDTH'(1);
      if (!printable) begin
        q_push        = in_string_r;
        cmd.op        = pse_pkg::OP_TERM;
        in_string_nxt = 1'b0;
        held_nxt      = '0;
      end else if (in_string_r) begin
        q_push = 1'b1;
      end else begin
        wr_en = room;
        if (reached) begin
          q_push        = 1'b1;
          cmd.op        = pse_pkg::OP_BURST;
          in_string_nxt = 1'b1;
          held_nxt      = '0;
          busy_nxt      = 1'b1;
        end else begin
          held_nxt = new_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      in_string_r <= 1'b0;
      pos_r       <= '0;
      busy_r      <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      in_string_r <= in_string_nxt;
      pos_r       <= pos_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

[rtl/pse_back.sv]
module pse_back #(
  parameter int MAX_MIN_LENGTH = 64,
  parameter int OFFSET_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  pse_pkg::cmd_t                       q_cmd,
  input  logic [$clog2(MAX_MIN_LENGTH+1)-1:0] q_count,
  input  logic [OFFSET_WIDTH-1:0]             q_offset,
  output logic                                q_pop,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_MIN_LENGTH)-1:0]   wr_addr,
  input  logic [7:0]                          wr_data,
  output logic                                burst_done,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_kind,
  output logic [7:0]                          out_char_out,
  output logic                                out_is_first,
  output logic [OFFSET_WIDTH-1:0]             out_start_offset,
  output logic                                out_last
);

  localparam int CW = $clog2(MAX_MIN_LENGTH + 1);
  localparam int AW = $clog2(MAX_MIN_LENGTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  logic [7:0] held_mem [MAX_MIN_LENGTH];

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [OFFSET_WIDTH-1:0] offset_r, offset_nxt;
  logic [7:0]              rd_data_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    kind_r, first_r, last_r;
  logic [7:0]              char_r;
  logic [OFFSET_WIDTH-1:0] start_r;

  logic                    can_load, load, is_last;
  logic                    ld_kind, ld_first, ld_last;
  logic [7:0]              ld_char;
  logic [OFFSET_WIDTH-1:0] ld_start;

  assign can_load         = !out_valid_r || out_pop;
  assign is_last          = (CW'(idx_r) == count_r - CW'(1));
  assign out_empty        = !out_valid_r;
  assign out_kind         = kind_r;
  assign out_char_out     = char_r;
  assign out_is_first     = first_r;
  assign out_start_offset = start_r;
  assign out_last         = last_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    offset_nxt = offset_r;
    q_pop      = 1'b0;
    burst_done = 1'b0;
    load       = 1'b0;
    ld_kind    = pse_pkg::KIND_CHAR;
    ld_char    = q_cmd.data;
    ld_first   = 1'b0;
    ld_start   = '0;
    ld_last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.op)
            pse_pkg::OP_BURST: begin
              q_pop      = 1'b1;
              idx_nxt    = '0;
              count_nxt  = q_count;
              offset_nxt = q_offset;
              state_nxt  = ST_READ;
            end
            pse_pkg::OP_TERM: begin
              if (can_load) begin
                q_pop   = 1'b1;
                load    = 1'b1;
                ld_kind = pse_pkg::KIND_TERM;
                ld_char = '0;
              end
            end
            default: begin
              if (can_load) begin
                q_pop = 1'b1;
                load  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          load     = 1'b1;
          ld_char  = rd_data_r;
          ld_first = (idx_r == '0);
          ld_start = (idx_r == '0) ? offset_r : '0;
          ld_last  = is_last;
          if (is_last) begin
            burst_done = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    count_r  <= count_nxt;
    offset_r <= offset_nxt;
    if (load) begin
      kind_r  <= ld_kind;
      char_r  <= ld_char;
      first_r <= ld_first;
      start_r <= ld_start;
      last_r  <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_mem[wr_addr] <= wr_data;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= held_mem[idx_r];
    end
  end

endmodule

[rtl/printable_string_extractor.sv]
// Scans a byte stream for runs of printable bytes (0x20..0x7e or tab) of at least
// min_length, capped at MAX_MIN_LENGTH, and hands them out as words: the bytes of a run
// are held until the run is long enough, then replayed as a burst whose first word
// carries the start offset (zero unless report_offset is set), and every further byte
// of the run passes straight through; a non-printable byte ends a reported string with
// a terminator word. An input byte is taken every cycle while no burst is in flight and
// the two-entry command queue has room. A burst is replayed by taking its command, then
// a held-byte memory read and an output load per byte; input stalls until the burst's
// last word has been loaded. The held-byte memory needs no clearing after reset.
module printable_string_extractor #(
  parameter int MAX_MIN_LENGTH = 64,
  parameter int OFFSET_WIDTH   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic [7:0]                         in_data_byte,
  output logic                               in_full,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_kind,
  output logic [7:0]                         out_char_out,
  output logic                               out_is_first,
  output logic [OFFSET_WIDTH-1:0]            out_start_offset,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pse_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_MIN_LENGTH + 1);
  localparam int AW = $clog2(MAX_MIN_LENGTH);
  localparam int QW = $bits(pse_pkg::cmd_t) + CW + OFFSET_WIDTH;

  logic [6:0] min_length_r;
  logic       report_offset_r;

  logic                    q_push, q_full, q_pop, q_empty;
  pse_pkg::cmd_t           f_cmd, b_cmd;
  logic [CW-1:0]           f_count, b_count;
  logic [OFFSET_WIDTH-1:0] f_offset, b_offset;
  logic [QW-1:0]           q_wdata, q_rdata;
  logic                    wr_en, burst_done;
  logic [AW-1:0]           wr_addr;
  logic [7:0]              wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r    <= pse_pkg::MIN_LENGTH_RESET;
      report_offset_r <= pse_pkg::REPORT_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pse_pkg::CFG_MIN_LENGTH:    min_length_r    <= cfg_data[6:0];
        pse_pkg::CFG_REPORT_OFFSET: report_offset_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pse_front #(
    .MAX_MIN_LENGTH (MAX_MIN_LENGTH),
    .OFFSET_WIDTH   (OFFSET_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_data_byte  (in_data_byte),
    .in_full       (in_full),
    .min_length    (min_length_r),
    .report_offset (report_offset_r),
    .q_full        (q_full),
    .burst_done    (burst_done),
    .q_push        (q_push),
    .cmd           (f_cmd),
    .cmd_count     (f_count),
    .cmd_offset    (f_offset),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  assign q_wdata  = {f_cmd, f_count, f_offset};
  assign b_cmd    = pse_pkg::cmd_t'(q_rdata[QW-1 -: $bits(pse_pkg::cmd_t)]);
  assign b_count  = q_rdata[OFFSET_WIDTH +: CW];
  assign b_offset = q_rdata[OFFSET_WIDTH-1:0];

  pse_cmdq #(
    .WIDTH (QW)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pse_back #(
    .MAX_MIN_LENGTH (MAX_MIN_LENGTH),
    .OFFSET_WIDTH   (OFFSET_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (b_cmd),
    .q_count          (b_count),
    .q_offset         (b_offset),
    .q_pop            (q_pop),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .burst_done       (burst_done),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_char_out     (out_char_out),
    .out_is_first     (out_is_first),
    .out_start_offset (out_start_offset),
    .out_last         (out_last)
  );

endmodule
